// ===== sv/fbpc_pkg.sv =====
// shared types, field positions and request codes for the frustum culling block
// no dependencies
package fbpc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COEF_W      = 14;
    localparam int COORD_W     = 22;
    localparam int PROD_W      = COEF_W + COORD_W;
    localparam int SUM_W       = 38;
    localparam int DIST_W      = 26;
    localparam int PLANE_W     = 64;
    localparam int ADDR_W      = 6;
    localparam int FRAC_SHIFT  = 12;

    localparam int A_LSB = 0;
    localparam int B_LSB = 14;
    localparam int C_LSB = 28;
    localparam int D_LSB = 42;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic [PLANE_W-1:0]        plane_word_t;

    typedef logic [1:0] req_t;
    localparam req_t REQ_BOX   = 2'd0;
    localparam req_t REQ_POINT = 2'd1;
    localparam req_t REQ_PLANE = 2'd2;

    typedef logic [2:0] pidx_t;
    localparam pidx_t PIDX_TOP   = 3'd5;
    localparam pidx_t PIDX_COUNT = 3'd6;

    typedef struct packed {
        req_t  req;
        pidx_t pidx;
    } ctl_t;

    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } mac_en_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    // extremal coordinate along one axis for the box test, lo otherwise
    function automatic coord_t pick_coord(coord_t lo, coord_t hi, logic neg, logic box);
        logic hi_gt;
        hi_gt = hi > lo;
        if (!box) begin
            return lo;
        end else if (neg) begin
            return hi_gt ? lo : hi;
        end else begin
            return hi_gt ? hi : lo;
        end
    endfunction

endpackage

// ===== sv/fbpc_cfg.sv =====
// apb register file holding the six frustum planes
// depends on fbpc_pkg
module fbpc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpc_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    output fbpc_pkg::plane_word_t       planes [fbpc_pkg::PLANE_COUNT]
);

    fbpc_pkg::plane_word_t plane_reg [fbpc_pkg::PLANE_COUNT];
    fbpc_pkg::pidx_t       idx;
    logic                  hit;

    assign idx    = paddr[5:3];
    assign hit    = idx < fbpc_pkg::PIDX_COUNT;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fbpc_pkg::PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && hit) begin
            plane_reg[idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = plane_reg[idx];
        end
    end

    always_comb begin
        for (int i = 0; i < fbpc_pkg::PLANE_COUNT; i++) begin
            planes[i] = plane_reg[i];
        end
    end

endmodule

// ===== sv/fbpc_plane_mac.sv =====
// one plane: three coefficient products, then exact sum with the offset
// depends on fbpc_pkg
module fbpc_plane_mac (
    input  logic                  aclk,
    input  fbpc_pkg::mac_en_t     en,
    input  fbpc_pkg::plane_word_t plane,
    input  fbpc_pkg::point_t      pt,
    output fbpc_pkg::sum_t        sum
);

    fbpc_pkg::coef_t  a;
    fbpc_pkg::coef_t  b;
    fbpc_pkg::coef_t  c;
    fbpc_pkg::coord_t d;

    fbpc_pkg::prod_t  px_reg;
    fbpc_pkg::prod_t  py_reg;
    fbpc_pkg::prod_t  pz_reg;
    fbpc_pkg::coord_t d_reg;
    fbpc_pkg::sum_t   sum_reg;
    fbpc_pkg::sum_t   sum_next;

    assign a = plane[fbpc_pkg::A_LSB +: fbpc_pkg::COEF_W];
    assign b = plane[fbpc_pkg::B_LSB +: fbpc_pkg::COEF_W];
    assign c = plane[fbpc_pkg::C_LSB +: fbpc_pkg::COEF_W];
    assign d = plane[fbpc_pkg::D_LSB +: fbpc_pkg::COORD_W];

    always_ff @(posedge aclk) begin
        if (en.load_prod) begin
            px_reg <= a * pt.x;
            py_reg <= b * pt.y;
            pz_reg <= c * pt.z;
            d_reg  <= d;
        end
    end

    assign sum_next = fbpc_pkg::SUM_W'(px_reg) + fbpc_pkg::SUM_W'(py_reg)
                    + fbpc_pkg::SUM_W'(pz_reg)
                    + (fbpc_pkg::SUM_W'(d_reg) <<< fbpc_pkg::FRAC_SHIFT);

    always_ff @(posedge aclk) begin
        if (en.load_sum) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== sv/fbpc_result.sv =====
// output stage: plane votes, distance rounding and the result register
// depends on fbpc_pkg
module fbpc_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic                  in_valid,
    input  fbpc_pkg::ctl_t        ctl,
    input  fbpc_pkg::sum_t        sums [fbpc_pkg::PLANE_COUNT],
    output logic                  out_valid,
    output logic                  is_visible,
    output fbpc_pkg::dist_t       plane_distance
);

    logic [fbpc_pkg::PLANE_COUNT-1:0] pos;
    fbpc_pkg::sum_t                   sel;
    logic signed [fbpc_pkg::SUM_W:0]  rnd;
    logic                             valid_reg;
    logic                             vis_reg;
    logic                             vis_next;
    fbpc_pkg::dist_t                  dist_reg;
    fbpc_pkg::dist_t                  dist_next;

    always_comb begin
        for (int i = 0; i < fbpc_pkg::PLANE_COUNT; i++) begin
            pos[i] = !sums[i][fbpc_pkg::SUM_W-1] && (sums[i] != '0);
        end
    end

    assign sel = sums[ctl.pidx];
    assign rnd = {sel[fbpc_pkg::SUM_W-1], sel} + (fbpc_pkg::SUM_W+1)'(2048);

    always_comb begin
        vis_next  = 1'b0;
        dist_next = '0;
        unique case (ctl.req)
            fbpc_pkg::REQ_BOX,
            fbpc_pkg::REQ_POINT: begin
                vis_next = &pos;
            end
            fbpc_pkg::REQ_PLANE: begin
                vis_next  = pos[ctl.pidx];
                dist_next = rnd[fbpc_pkg::SUM_W-1:fbpc_pkg::FRAC_SHIFT];
            end
            default: begin
                vis_next  = 1'b0;
                dist_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vis_reg  <= vis_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid      = valid_reg;
    assign is_visible     = vis_reg;
    assign plane_distance = dist_reg;

endmodule

// ===== sv/frustum_box_point_cull.sv =====
// top level of the frustum culling block: corner select stage and pipeline control
// depends on fbpc_pkg, fbpc_cfg, fbpc_plane_mac, fbpc_result
//
// usage:
//   planes are written over the apb port at byte address 8*i (near, far, left,
//   right, bottom, top), by the user only while no item is in flight; not enforced
//   s_ channel takes one request item per cycle while s_tready is high; tuser
//   carries the request kind and plane index, tdata the lo and hi corners
//   m_ channel returns one result item per request, in order
//   pipeline: four register stages (corner select, products, sum, decision);
//   m_tvalid rises when the item is loaded into the decision register
//   throughput: one item per cycle while m_tready stays high, set by the four
//   stage pipeline with one multiplier per plane axis
//   reset clears all planes to zero and empties the pipeline
//   when the receiver stalls, each stage holds its item; a stage that holds a
//   bubble still takes a new item, so s_tready falls only when all stages are full
module frustum_box_point_cull (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (22 bits each), 4 zero bits
    input  logic [135:0]                s_tdata,
    // req_type [1:0], plane_index [4:2]
    input  logic [4:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // is_visible [0], plane_distance [26:1], 5 zero bits
    output logic [31:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpc_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    fbpc_pkg::plane_word_t planes [fbpc_pkg::PLANE_COUNT];
    fbpc_pkg::sum_t        sums   [fbpc_pkg::PLANE_COUNT];

    fbpc_pkg::point_t lo;
    fbpc_pkg::point_t hi;
    fbpc_pkg::ctl_t   ctl_in;
    logic             box;

    fbpc_pkg::point_t pt1_reg [fbpc_pkg::PLANE_COUNT];
    fbpc_pkg::ctl_t   ctl1_reg;
    fbpc_pkg::ctl_t   ctl2_reg;
    fbpc_pkg::ctl_t   ctl3_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    logic             rdy4;
    fbpc_pkg::mac_en_t mac_en;

    logic             vis;
    fbpc_pkg::dist_t  distance;

    fbpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    assign lo.x = s_tdata[21:0];
    assign lo.y = s_tdata[43:22];
    assign lo.z = s_tdata[65:44];
    assign hi.x = s_tdata[87:66];
    assign hi.y = s_tdata[109:88];
    assign hi.z = s_tdata[131:110];

    always_comb begin
        ctl_in.req  = s_tuser[1:0];
        ctl_in.pidx = s_tuser[4:2];
        if (s_tuser[4:2] > fbpc_pkg::PIDX_TOP) begin
            ctl_in.pidx = fbpc_pkg::PIDX_TOP;
        end
    end

    assign box = ctl_in.req == fbpc_pkg::REQ_BOX;

    assign rdy4     = !m_tvalid || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign mac_en.load_prod = rdy2;
    assign mac_en.load_sum  = rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            ctl1_reg <= ctl_in;
            for (int p = 0; p < fbpc_pkg::PLANE_COUNT; p++) begin
                pt1_reg[p].x <= fbpc_pkg::pick_coord(lo.x, hi.x,
                    planes[p][fbpc_pkg::B_LSB-1], box);
                pt1_reg[p].y <= fbpc_pkg::pick_coord(lo.y, hi.y,
                    planes[p][fbpc_pkg::C_LSB-1], box);
                pt1_reg[p].z <= fbpc_pkg::pick_coord(lo.z, hi.z,
                    planes[p][fbpc_pkg::D_LSB-1], box);
            end
        end
        if (rdy2) begin
            ctl2_reg <= ctl1_reg;
        end
        if (rdy3) begin
            ctl3_reg <= ctl2_reg;
        end
    end

    for (genvar p = 0; p < fbpc_pkg::PLANE_COUNT; p++) begin : g_plane
        fbpc_plane_mac u_mac (
            .aclk  (aclk),
            .en    (mac_en),
            .plane (planes[p]),
            .pt    (pt1_reg[p]),
            .sum   (sums[p])
        );
    end

    fbpc_result u_result (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (rdy4),
        .in_valid       (v3_reg),
        .ctl            (ctl3_reg),
        .sums           (sums),
        .out_valid      (m_tvalid),
        .is_visible     (vis),
        .plane_distance (distance)
    );

    assign m_tdata = {5'b0, distance, vis};

`ifndef SYNTH
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && m_tvalid))
        else $error("input stalled with a free stage");

    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(ctl3_reg)))
        else $error("stage three item lost under stall");

    a_index_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (ctl1_reg.pidx <= fbpc_pkg::PIDX_TOP))
        else $error("plane index not clamped");

    a_accept_reaches_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item missing from first stage");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// testbench for frustum_box_point_cull: box, point and single plane requests
// against several plane sets, checked item by item against a predictor in this file
// depends on fbpc_pkg and the frustum_box_point_cull rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        fbpc_pkg::req_t   req;
        fbpc_pkg::pidx_t  pidx;
        fbpc_pkg::point_t lo;
        fbpc_pkg::point_t hi;
    } cull_req_t;

    typedef struct {
        logic            vis;
        fbpc_pkg::dist_t distance;
    } cull_result_t;

    typedef enum int {PL_NEAR, PL_FAR, PL_LEFT, PL_RIGHT, PL_BOTTOM, PL_TOP} plane_sel_e;

    localparam fbpc_pkg::req_t REQ_NONE = 2'd3;
    localparam int UNIT      = 256;
    localparam int ONE       = 4096;
    localparam int CUBE      = 100 * UNIT;
    localparam int SPAN      = 150 * UNIT;
    localparam int COEF_MAX  = 8191;
    localparam int COEF_MIN  = -8192;
    localparam int COORD_MAX = 2097151;
    localparam int COORD_MIN = -2097152;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (22 bits each), 4 zero bits
    logic [135:0]                s_tdata  = '0;
    // req_type [1:0], plane_index [4:2]
    logic [4:0]                  s_tuser  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    // is_visible [0], plane_distance [26:1], 5 zero bits
    logic [31:0]                 m_tdata;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [fbpc_pkg::ADDR_W-1:0] paddr    = '0;
    logic [63:0]                 pwdata   = '0;
    logic [63:0]                 prdata;
    logic                        pready;

    frustum_box_point_cull dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    fbpc_pkg::plane_word_t plane_mirror [fbpc_pkg::PLANE_COUNT] = '{default: '0};
    cull_req_t    pending_items [$];
    cull_result_t expected_results [$];

    int errors     = 0;
    int n_box      = 0;
    int n_point    = 0;
    int n_plane    = 0;
    int n_other    = 0;
    int n_checked  = 0;
    int n_settings = 0;
    bit quiet      = 1'b0;
    bit s_took     = 1'b0;
    int s_gap      = 0;
    int m_gap      = 0;

    function automatic fbpc_pkg::plane_word_t pack_plane(int a, int b, int c, int d);
        return {fbpc_pkg::coord_t'(d), fbpc_pkg::coef_t'(c), fbpc_pkg::coef_t'(b),
                fbpc_pkg::coef_t'(a)};
    endfunction

    function automatic longint plane_dist_q20(fbpc_pkg::plane_word_t w,
                                              fbpc_pkg::coord_t x, fbpc_pkg::coord_t y,
                                              fbpc_pkg::coord_t z);
        fbpc_pkg::coef_t  a;
        fbpc_pkg::coef_t  b;
        fbpc_pkg::coef_t  c;
        fbpc_pkg::coord_t d;
        a = w[fbpc_pkg::A_LSB +: fbpc_pkg::COEF_W];
        b = w[fbpc_pkg::B_LSB +: fbpc_pkg::COEF_W];
        c = w[fbpc_pkg::C_LSB +: fbpc_pkg::COEF_W];
        d = w[fbpc_pkg::D_LSB +: fbpc_pkg::COORD_W];
        return longint'(a) * longint'(x) + longint'(b) * longint'(y)
             + longint'(c) * longint'(z) + longint'(d) * 4096;
    endfunction

    function automatic cull_result_t predict_cull(cull_req_t r);
        cull_result_t     res;
        longint           s;
        bit               any_pos;
        int               idx;
        fbpc_pkg::coord_t x;
        fbpc_pkg::coord_t y;
        fbpc_pkg::coord_t z;
        res.vis      = 1'b0;
        res.distance = '0;
        case (r.req)
            fbpc_pkg::REQ_BOX: begin
                res.vis = 1'b1;
                for (int p = 0; p < fbpc_pkg::PLANE_COUNT; p++) begin
                    any_pos = 1'b0;
                    for (int k = 0; k < 8; k++) begin
                        x = k[0] ? r.hi.x : r.lo.x;
                        y = k[1] ? r.hi.y : r.lo.y;
                        z = k[2] ? r.hi.z : r.lo.z;
                        if (plane_dist_q20(plane_mirror[p], x, y, z) > 0)
                            any_pos = 1'b1;
                    end
                    if (!any_pos)
                        res.vis = 1'b0;
                end
            end
            fbpc_pkg::REQ_POINT: begin
                res.vis = 1'b1;
                for (int p = 0; p < fbpc_pkg::PLANE_COUNT; p++) begin
                    if (plane_dist_q20(plane_mirror[p], r.lo.x, r.lo.y, r.lo.z) <= 0)
                        res.vis = 1'b0;
                end
            end
            fbpc_pkg::REQ_PLANE: begin
                idx = (r.pidx > fbpc_pkg::PIDX_TOP) ? fbpc_pkg::PIDX_TOP : r.pidx;
                s = plane_dist_q20(plane_mirror[idx], r.lo.x, r.lo.y, r.lo.z);
                res.vis      = (s > 0);
                res.distance = fbpc_pkg::dist_t'((s + 2048) >>> 12);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int rand_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic cull_req_t random_item(bit wild);
        cull_req_t        r;
        int               pick;
        fbpc_pkg::point_t t;
        pick = $urandom_range(0, 99);
        r.req = (pick < 40) ? fbpc_pkg::REQ_BOX :
                (pick < 70) ? fbpc_pkg::REQ_POINT :
                (pick < 97) ? fbpc_pkg::REQ_PLANE : REQ_NONE;
        r.pidx = fbpc_pkg::pidx_t'($urandom_range(0, 7));
        if (wild) begin
            r.lo.x = fbpc_pkg::coord_t'($urandom);
            r.lo.y = fbpc_pkg::coord_t'($urandom);
            r.lo.z = fbpc_pkg::coord_t'($urandom);
            r.hi.x = fbpc_pkg::coord_t'($urandom);
            r.hi.y = fbpc_pkg::coord_t'($urandom);
            r.hi.z = fbpc_pkg::coord_t'($urandom);
        end else begin
            r.lo.x = fbpc_pkg::coord_t'(rand_signed(SPAN));
            r.lo.y = fbpc_pkg::coord_t'(rand_signed(SPAN));
            r.lo.z = fbpc_pkg::coord_t'(rand_signed(SPAN));
            r.hi.x = fbpc_pkg::coord_t'(r.lo.x + $urandom_range(0, 60 * UNIT));
            r.hi.y = fbpc_pkg::coord_t'(r.lo.y + $urandom_range(0, 60 * UNIT));
            r.hi.z = fbpc_pkg::coord_t'(r.lo.z + $urandom_range(0, 60 * UNIT));
            if ($urandom_range(0, 9) == 0) begin
                t    = r.lo;
                r.lo = r.hi;
                r.hi = t;
            end
        end
        return r;
    endfunction

    function automatic cull_req_t mk_item(fbpc_pkg::req_t rq, int pi, int lx, int ly,
                                          int lz, int hx, int hy, int hz);
        cull_req_t r;
        r.req  = rq;
        r.pidx = fbpc_pkg::pidx_t'(pi);
        r.lo.x = fbpc_pkg::coord_t'(lx);
        r.lo.y = fbpc_pkg::coord_t'(ly);
        r.lo.z = fbpc_pkg::coord_t'(lz);
        r.hi.x = fbpc_pkg::coord_t'(hx);
        r.hi.y = fbpc_pkg::coord_t'(hy);
        r.hi.z = fbpc_pkg::coord_t'(hz);
        return r;
    endfunction

    task automatic apb_xfer(input bit wr, input int idx, input fbpc_pkg::plane_word_t wdata,
                            output fbpc_pkg::plane_word_t rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = fbpc_pkg::ADDR_W'(8 * idx);
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_plane(int idx, fbpc_pkg::plane_word_t w);
        fbpc_pkg::plane_word_t rb;
        apb_xfer(1'b1, idx, w, rb);
        plane_mirror[idx] = w;
        apb_xfer(1'b0, idx, '0, rb);
        if (rb !== w) begin
            $error("plane %0d readback: expected %h actual %h", idx, w, rb);
            errors++;
        end
    endtask

    task automatic load_planes(fbpc_pkg::plane_word_t w0, fbpc_pkg::plane_word_t w1,
                               fbpc_pkg::plane_word_t w2, fbpc_pkg::plane_word_t w3,
                               fbpc_pkg::plane_word_t w4, fbpc_pkg::plane_word_t w5);
        set_plane(PL_NEAR, w0);
        set_plane(PL_FAR, w1);
        set_plane(PL_LEFT, w2);
        set_plane(PL_RIGHT, w3);
        set_plane(PL_BOTTOM, w4);
        set_plane(PL_TOP, w5);
        n_settings++;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item($urandom_range(0, 4) == 0));
    endtask

    // input side: acceptance and prediction at the rising edge
    always @(posedge aclk) begin
        s_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(predict_cull(pending_items[0]));
            case (pending_items[0].req)
                fbpc_pkg::REQ_BOX:   n_box++;
                fbpc_pkg::REQ_POINT: n_point++;
                fbpc_pkg::REQ_PLANE: n_plane++;
                default:             n_other++;
            endcase
            pending_items.pop_front();
        end
    end

    // input side: drive at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
            s_tvalid <= 1'b1;
        end else if (s_gap > 0) begin
            s_gap    <= s_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                s_gap    <= $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= {pending_items[0].pidx, pending_items[0].req};
                s_tdata  <= {4'b0, pending_items[0].hi, pending_items[0].lo};
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side: backpressure at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap    <= m_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_gap    <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result side: compare at the rising edge
    always @(posedge aclk) begin
        cull_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_checked++;
            if (expected_results.size() == 0) begin
                $error("result item with none expected: is_visible %0d plane_distance %0d",
                       m_tdata[0], $signed(m_tdata[26:1]));
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.vis) begin
                    $error("is_visible: expected %0d actual %0d", want.vis, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[26:1] !== want.distance) begin
                    $error("plane_distance: expected %0d actual %0d",
                           want.distance, $signed(m_tdata[26:1]));
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // all planes zero after reset: every distance is zero
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, -UNIT, -UNIT, -UNIT,
                                        UNIT, UNIT, UNIT));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_POINT, 0, UNIT, UNIT, UNIT, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_FAR, COORD_MAX, COORD_MIN,
                                        UNIT, 0, 0, 0));
        drain();

        // axis aligned cube of half size 100
        load_planes(pack_plane(0, 0, ONE, CUBE), pack_plane(0, 0, -ONE, CUBE),
                    pack_plane(ONE, 0, 0, CUBE), pack_plane(-ONE, 0, 0, CUBE),
                    pack_plane(0, ONE, 0, CUBE), pack_plane(0, -ONE, 0, CUBE));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, -10 * UNIT, -10 * UNIT,
                                        -10 * UNIT, 10 * UNIT, 10 * UNIT, 10 * UNIT));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, 150 * UNIT, 0, 0,
                                        200 * UNIT, UNIT, UNIT));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, 50 * UNIT, 0, 0,
                                        150 * UNIT, UNIT, UNIT));
        // box touching the left plane only at zero distance
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, -150 * UNIT, 0, 0,
                                        -CUBE, UNIT, UNIT));
        // lo above hi
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, 10 * UNIT, 10 * UNIT,
                                        10 * UNIT, -10 * UNIT, -10 * UNIT, -10 * UNIT));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, COORD_MIN, COORD_MIN,
                                        COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_POINT, 0, 0, 0, 0,
                                        COORD_MIN, COORD_MIN, COORD_MIN));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_POINT, 0, CUBE, 0, 0, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_POINT, 0, 0, 0, -300 * UNIT,
                                        0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_POINT, 0, COORD_MAX, COORD_MAX,
                                        COORD_MAX, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_RIGHT, 25 * UNIT, 0, 0,
                                        0, 0, 0));
        pending_items.push_back(mk_item(REQ_NONE, PL_TOP, UNIT, UNIT, UNIT,
                                        UNIT, UNIT, UNIT));
        drain();

        // odd coefficients for rounding ties and field extremes
        load_planes(pack_plane(1, 0, 0, 0),
                    pack_plane(COEF_MIN, COEF_MAX, -1, COORD_MIN),
                    pack_plane(0, 0, 0, 1),
                    pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COORD_MAX),
                    pack_plane(-1, -1, -1, -1),
                    pack_plane(3, -5, 7, -129));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_NEAR, 2048, 0, 0, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_NEAR, -2048, 0, 0, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_NEAR, 2047, 0, 0, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_FAR, COORD_MIN, COORD_MAX,
                                        COORD_MIN, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_LEFT, COORD_MAX, 0,
                                        COORD_MIN, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, PL_RIGHT, COORD_MAX, COORD_MAX,
                                        COORD_MAX, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, 6, 1000, -333, 77, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_PLANE, 7, 1, 1, 1, 0, 0, 0));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_BOX, 0, COORD_MIN, COORD_MIN,
                                        COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        pending_items.push_back(mk_item(fbpc_pkg::REQ_POINT, 0, -UNIT, 3, -UNIT, 0, 0, 0));
        drain();

        // random part, odd coefficient planes still loaded
        push_random(300);
        drain();

        load_planes(pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COORD_MAX),
                    pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COORD_MIN),
                    '1, '0,
                    pack_plane(COEF_MAX, COEF_MIN, COEF_MAX, COORD_MIN),
                    pack_plane(COEF_MIN, COEF_MAX, COEF_MIN, COORD_MAX));
        push_random(250);
        drain();

        load_planes('1,
                    pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COORD_MAX),
                    pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COORD_MIN),
                    pack_plane(COEF_MIN, COEF_MAX, COEF_MIN, COORD_MAX),
                    '0,
                    pack_plane(COEF_MAX, COEF_MIN, COEF_MAX, COORD_MIN));
        push_random(250);
        drain();

        // tilted frustum of moderate size
        load_planes(pack_plane(rand_signed(ONE), rand_signed(ONE), rand_signed(ONE),
                               rand_signed(CUBE)),
                    pack_plane(rand_signed(ONE), rand_signed(ONE), rand_signed(ONE),
                               rand_signed(CUBE)),
                    pack_plane(rand_signed(ONE), rand_signed(ONE), rand_signed(ONE),
                               rand_signed(CUBE)),
                    pack_plane(rand_signed(ONE), rand_signed(ONE), rand_signed(ONE),
                               rand_signed(CUBE)),
                    pack_plane(rand_signed(ONE), rand_signed(ONE), rand_signed(ONE),
                               rand_signed(CUBE)),
                    pack_plane(rand_signed(ONE), rand_signed(ONE), rand_signed(ONE),
                               rand_signed(CUBE)));
        push_random(300);
        drain();

        load_planes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        push_random(200);
        drain();

        // last part runs at full rate on both sides
        quiet = 1'b1;
        load_planes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        push_random(200);
        drain();
        repeat (8) @(posedge aclk);

        $display("covered %0d box, %0d point, %0d single plane and %0d unused kind requests",
                 n_box, n_point, n_plane, n_other);
        $display("over %0d plane sets, %0d result items compared, %0d mismatches",
                 n_settings + 1, n_checked, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
